// File: hdl/ringtone_text_note_parser_top_defines.svh
// Assertion macros for the ringtone text note parser checker
`ifndef RINGTONE_TEXT_NOTE_PARSER_TOP_DEFINES_SVH
`define RINGTONE_TEXT_NOTE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset
`define RTNP_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ringtone parser check failed");

// Next-cycle implication, sampled on the rising clock, idle during reset
`define RTNP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ringtone parser check failed");

`endif

// File: hdl/rtnp_pkg.sv
// Shared types and constants for the ringtone text note parser
`default_nettype none

package rtnp_pkg;

    // Field widths
    localparam int VAL_W  = 10;
    localparam int FREQ_W = 17;
    localparam int DUR_W  = 17;
    localparam int GAP_W  = 14;
    localparam int PROD_W = 2 * VAL_W;
    localparam int TDATA_W = 48;
    localparam int TUSER_W = 2;

    // Saturation values
    localparam logic [DUR_W-1:0] DUR_MAX = '1;
    localparam logic [GAP_W-1:0] GAP_MAX = '1;

    // Divide numerators
    localparam logic [DUR_W-1:0] NUM_PLAIN  = 17'd60000;
    localparam logic [DUR_W-1:0] NUM_DOTTED = 17'd90000;
    localparam logic [DUR_W-1:0] NUM_GAP    = 17'd9000;

    // Divide sequencing: one quotient bit per step
    localparam int DIV_STEPS = DUR_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Character codes
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_4     = 8'h34;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LP    = 8'h70;

    // Tone indexes (sharp is the next index)
    localparam logic [3:0] TONE_REST = 4'd0;
    localparam logic [3:0] TONE_C    = 4'd1;
    localparam logic [3:0] TONE_D    = 4'd3;
    localparam logic [3:0] TONE_E    = 4'd5;
    localparam logic [3:0] TONE_F    = 4'd6;
    localparam logic [3:0] TONE_G    = 4'd8;
    localparam logic [3:0] TONE_A    = 4'd10;
    localparam logic [3:0] TONE_B    = 4'd12;

    // Note handed from the parser to the datapath
    typedef struct packed {
        logic              emit;
        logic              last;
        logic              dotted;
        logic [FREQ_W-1:0] freq;
        logic [VAL_W-1:0]  tempo;
        logic [VAL_W-1:0]  nlen;
    } note_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic publish;
    } cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic out_free;
    } stat_t;

    // Octave-4 tone value in 1/128 Hz
    function automatic logic [FREQ_W-1:0] tone_lookup(input logic [3:0] idx);
        logic [FREQ_W-1:0] t;
        begin
            case (idx)
                4'd1:    t = 17'd66976;
                4'd2:    t = 17'd70959;
                4'd3:    t = 17'd75178;
                4'd4:    t = 17'd79649;
                4'd5:    t = 17'd84385;
                4'd6:    t = 17'd89402;
                4'd7:    t = 17'd94719;
                4'd8:    t = 17'd100351;
                4'd9:    t = 17'd106318;
                4'd10:   t = 17'd56320;
                4'd11:   t = 17'd59669;
                4'd12:   t = 17'd63217;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/ringtone_text_note_parser_top.sv
// Ringtone text note parser: takes characters, returns timed notes.
// A character that does not end a note leaves the sequencer idle, ready for the next one.
// A note-ending character loads the operands on the edge that takes it, then yields its item
// through the product, 17 steps of the restoring divider pair and the output load.
// The next character is taken the cycle after the output load; a held output stalls it.
// Reset leaves the parser waiting for a start character and the output empty.
`default_nettype none

module ringtone_text_note_parser_top #(
    parameter int HEADER_DIGITS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tuser,   // [0] start_tune
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [16:0] freq_sixteenths, [33:17] duration_ms,
                                             // [47:34] gap_ms
    output logic [1:0]       m_axis_tuser,   // [0] is_rest, [1] bad_tempo
    output logic             m_axis_tlast    // is_last
);

    rtnp_pkg::note_t note;
    rtnp_pkg::cmd_t  cmd;
    rtnp_pkg::stat_t stat;
    logic            in_acc;

    // Input item taken
    assign in_acc = s_axis_tvalid && s_axis_tready;

    rtnp_parse #(
        .HEADER_DIGITS (HEADER_DIGITS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (in_acc),
        .ch      (s_axis_tdata),
        .restart (s_axis_tuser),
        .note    (note)
    );

    rtnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_acc    (in_acc),
        .note_emit (note.emit),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_axis_tready)
    );

    rtnp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .note      (note),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: hdl/rtnp_parse.sv
// Character parser: header fields, note elements and note frequency
`default_nettype none

module rtnp_parse #(
    parameter int HEADER_DIGITS = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic [7:0]    ch,
    input  wire logic          restart,
    output rtnp_pkg::note_t    note
);

    localparam int DCW_RAW = $clog2(HEADER_DIGITS + 1);
    localparam int DCW     = (DCW_RAW > 2) ? DCW_RAW : 2;
    localparam logic [DCW-1:0] DC_FULL = DCW'(HEADER_DIGITS);
    localparam logic [DCW-1:0] DC_KEY  = DCW'(2);

    localparam logic [3:0] PH_NAME  = 4'd0;
    localparam logic [3:0] PH_DKEY  = 4'd1;
    localparam logic [3:0] PH_DNUM  = 4'd2;
    localparam logic [3:0] PH_OKEY  = 4'd3;
    localparam logic [3:0] PH_ONUM  = 4'd4;
    localparam logic [3:0] PH_BKEY  = 4'd5;
    localparam logic [3:0] PH_BNUM  = 4'd6;
    localparam logic [3:0] PH_LEN   = 4'd7;
    localparam logic [3:0] PH_THREE = 4'd8;
    localparam logic [3:0] PH_LET   = 4'd9;
    localparam logic [3:0] PH_SHP   = 4'd10;
    localparam logic [3:0] PH_OCT   = 4'd11;
    localparam logic [3:0] PH_DOT   = 4'd12;
    localparam logic [3:0] PH_END   = 4'd13;
    localparam logic [3:0] PH_DONE  = 4'd14;

    localparam int VW = rtnp_pkg::VAL_W;
    localparam int FW = rtnp_pkg::FREQ_W;

    logic [3:0]    phase_reg, phase_next;
    logic [VW-1:0] accum_reg, accum_next;
    logic [DCW-1:0] count_reg, count_next;
    logic [VW-1:0] dlen_reg, dlen_next;
    logic [VW-1:0] doct_reg, doct_next;
    logic [VW-1:0] tempo_reg, tempo_next;
    logic [VW-1:0] nlen_reg, nlen_next;
    logic [3:0]    base_reg, base_next;
    logic [FW-1:0] lfreq_reg, lfreq_next;
    logic          dotted_reg, dotted_next;
    logic          pend_reg, pend_next;
    logic [2:0]    noct_reg, noct_next;

    logic          emit_c, last_c;

    // Frequency of the note in progress
    logic [VW-1:0] oct_use;
    logic          oct_ok;
    logic [1:0]    sh;
    logic [FW:0]   half, fsum;
    logic [FW-1:0] freq_c;

    always_comb
    begin
        oct_use = (noct_reg != 3'd0) ? VW'(noct_reg) : doct_reg;
        oct_ok  = (oct_use >= VW'(4)) && (oct_use <= VW'(7));
        sh      = 2'(3'd7 - oct_use[2:0]);
        half    = (sh == 2'd0) ? '0 : ((FW+1)'(1) << (sh - 2'd1));
        fsum    = {1'b0, rtnp_pkg::tone_lookup(base_reg)} + half;
        freq_c  = oct_ok ? FW'(fsum >> sh) : lfreq_reg;
    end

    // Header digit accumulation
    logic [13:0] dig_val;
    logic        dig_ok;

    always_comb
    begin
        dig_ok  = (ch >= rtnp_pkg::CH_0) && (ch <= rtnp_pkg::CH_9) && (count_reg < DC_FULL);
        dig_val = 14'({4'b0, accum_reg}) * 14'd10 + 14'(ch - rtnp_pkg::CH_0);
    end

    // Letter decode
    logic [3:0] let_idx;
    logic       let_sharp, let_hit;

    always_comb
    begin
        let_idx   = rtnp_pkg::TONE_REST;
        let_sharp = 1'b0;
        let_hit   = 1'b1;
        unique case (ch)
            rtnp_pkg::CH_LC: begin let_idx = rtnp_pkg::TONE_C; let_sharp = 1'b1; end
            rtnp_pkg::CH_LD: begin let_idx = rtnp_pkg::TONE_D; let_sharp = 1'b1; end
            rtnp_pkg::CH_LE: let_idx = rtnp_pkg::TONE_E;
            rtnp_pkg::CH_LF: begin let_idx = rtnp_pkg::TONE_F; let_sharp = 1'b1; end
            rtnp_pkg::CH_LG: begin let_idx = rtnp_pkg::TONE_G; let_sharp = 1'b1; end
            rtnp_pkg::CH_LA: begin let_idx = rtnp_pkg::TONE_A; let_sharp = 1'b1; end
            rtnp_pkg::CH_LB: let_idx = rtnp_pkg::TONE_B;
            rtnp_pkg::CH_LP: let_idx = rtnp_pkg::TONE_REST;
            default:         let_hit = 1'b0;
        endcase
    end

    // Next state of the parser
    logic handled;
    logic [DCW-1:0] cnt_inc;

    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        count_next  = count_reg;
        dlen_next   = dlen_reg;
        doct_next   = doct_reg;
        tempo_next  = tempo_reg;
        nlen_next   = nlen_reg;
        base_next   = base_reg;
        lfreq_next  = lfreq_reg;
        dotted_next = dotted_reg;
        pend_next   = pend_reg;
        noct_next   = noct_reg;
        emit_c      = 1'b0;
        last_c      = 1'b0;
        handled     = 1'b0;
        cnt_inc     = count_reg + DCW'(1);

        if (restart)
        begin
            phase_next = PH_NAME;
            accum_next = '0;
            count_next = '0;
            base_next  = rtnp_pkg::TONE_REST;
            lfreq_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_NAME:
                begin
                    if (ch == rtnp_pkg::CH_COLON)
                    begin
                        phase_next = PH_DKEY;
                        count_next = '0;
                    end
                end
                PH_DKEY, PH_OKEY, PH_BKEY:
                begin
                    // skip two key characters
                    if (cnt_inc >= DC_KEY)
                    begin
                        phase_next = phase_reg + 4'd1;
                        count_next = '0;
                        accum_next = '0;
                    end
                    else
                        count_next = cnt_inc;
                end
                PH_DNUM, PH_ONUM, PH_BNUM:
                begin
                    if (phase_reg == PH_DNUM && ch == rtnp_pkg::CH_COMMA)
                    begin
                        dlen_next  = accum_reg;
                        phase_next = PH_OKEY;
                        count_next = '0;
                    end
                    else if (phase_reg == PH_ONUM && ch == rtnp_pkg::CH_COMMA)
                    begin
                        doct_next  = accum_reg;
                        phase_next = PH_BKEY;
                        count_next = '0;
                    end
                    else if (phase_reg == PH_BNUM && ch == rtnp_pkg::CH_COLON)
                    begin
                        tempo_next  = accum_reg;
                        phase_next  = PH_LEN;
                        nlen_next   = dlen_reg;
                        dotted_next = 1'b0;
                        noct_next   = '0;
                        pend_next   = 1'b0;
                    end
                    else if (dig_ok)
                    begin
                        accum_next = (dig_val > 14'd1023) ? '1 : VW'(dig_val);
                        count_next = cnt_inc;
                    end
                    else
                        count_next = DC_FULL;
                end
                PH_LEN, PH_THREE, PH_LET, PH_SHP, PH_OCT, PH_DOT, PH_END:
                begin
                    if (phase_reg == PH_THREE)
                    begin
                        handled = 1'b1;
                        if (ch == rtnp_pkg::CH_2)
                        begin
                            nlen_next  = VW'(32);
                            phase_next = PH_LET;
                        end
                        else
                        begin
                            emit_c = 1'b1;
                            last_c = 1'b1;
                        end
                    end
                    else
                    begin
                        pend_next = 1'b0;
                        if (pend_reg && ch == rtnp_pkg::CH_6)
                        begin
                            nlen_next = VW'(16);
                            handled   = 1'b1;
                        end
                        // length digit
                        if (!handled && phase_reg == PH_LEN)
                        begin
                            handled = 1'b1;
                            unique case (ch)
                                rtnp_pkg::CH_3: phase_next = PH_THREE;
                                rtnp_pkg::CH_1:
                                begin
                                    nlen_next  = VW'(1);
                                    pend_next  = 1'b1;
                                    phase_next = PH_LET;
                                end
                                rtnp_pkg::CH_8: begin nlen_next = VW'(8); phase_next = PH_LET; end
                                rtnp_pkg::CH_4: begin nlen_next = VW'(4); phase_next = PH_LET; end
                                rtnp_pkg::CH_2: begin nlen_next = VW'(2); phase_next = PH_LET; end
                                default:        handled = 1'b0;
                            endcase
                        end
                        // letter or rest
                        if (!handled && phase_reg <= PH_LET && let_hit)
                        begin
                            handled    = 1'b1;
                            base_next  = let_idx;
                            phase_next = let_sharp ? PH_SHP : PH_OCT;
                        end
                        // sharp
                        if (!handled && phase_reg == PH_SHP && ch == rtnp_pkg::CH_HASH)
                        begin
                            handled    = 1'b1;
                            base_next  = base_reg + 4'd1;
                            phase_next = PH_OCT;
                        end
                        // octave digit
                        if (!handled && phase_reg <= PH_OCT &&
                            ch >= rtnp_pkg::CH_4 && ch <= rtnp_pkg::CH_7)
                        begin
                            handled    = 1'b1;
                            noct_next  = 3'(ch - rtnp_pkg::CH_0);
                            phase_next = PH_DOT;
                        end
                        // dot
                        if (!handled && phase_reg <= PH_DOT && ch == rtnp_pkg::CH_DOT)
                        begin
                            handled     = 1'b1;
                            dotted_next = 1'b1;
                            phase_next  = PH_END;
                        end
                        if (!handled)
                        begin
                            emit_c = 1'b1;
                            last_c = (ch != rtnp_pkg::CH_COMMA);
                        end
                    end

                    // close the note: remember frequency, then end or begin the next
                    if (emit_c)
                    begin
                        if (oct_ok)
                            lfreq_next = freq_c;
                        if (last_c)
                            phase_next = PH_DONE;
                        else
                        begin
                            phase_next  = PH_LEN;
                            nlen_next   = dlen_reg;
                            dotted_next = 1'b0;
                            noct_next   = '0;
                            pend_next   = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // waiting for a start
                end
            endcase
        end
    end

    // Parser registers advance on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DONE;
            accum_reg  <= '0;
            count_reg  <= '0;
            dlen_reg   <= '0;
            doct_reg   <= '0;
            tempo_reg  <= '0;
            nlen_reg   <= '0;
            base_reg   <= rtnp_pkg::TONE_REST;
            lfreq_reg  <= '0;
            dotted_reg <= 1'b0;
            pend_reg   <= 1'b0;
            noct_reg   <= '0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            count_reg  <= count_next;
            dlen_reg   <= dlen_next;
            doct_reg   <= doct_next;
            tempo_reg  <= tempo_next;
            nlen_reg   <= nlen_next;
            base_reg   <= base_next;
            lfreq_reg  <= lfreq_next;
            dotted_reg <= dotted_next;
            pend_reg   <= pend_next;
            noct_reg   <= noct_next;
        end
    end

    // Present the finished note
    always_comb
    begin
        note.emit   = adv && emit_c;
        note.last   = last_c;
        note.dotted = dotted_reg;
        note.freq   = freq_c;
        note.tempo  = tempo_reg;
        note.nlen   = nlen_reg;
    end

endmodule

`default_nettype wire

// File: hdl/rtnp_ctrl.sv
// Sequencer for note timing: load, multiply, divide steps, output
`default_nettype none

module rtnp_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_acc,
    input  wire logic        note_emit,
    input  wire rtnp_pkg::stat_t stat,
    output rtnp_pkg::cmd_t   cmd,
    output logic             in_ready
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MUL  = 2'd1;
    localparam logic [1:0] C_DIV  = 2'd2;
    localparam logic [1:0] C_OUT  = 2'd3;

    localparam int CW = rtnp_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_LAST = CW'(rtnp_pkg::DIV_STEPS - 1);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // State transitions and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.load    = 1'b0;
        cmd.start   = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        in_ready    = 1'b0;
        unique case (state_reg)
            C_IDLE:
            begin
                in_ready = 1'b1;
                if (in_acc && note_emit)
                begin
                    cmd.load   = 1'b1;
                    state_next = C_MUL;
                end
            end
            C_MUL:
            begin
                cmd.start  = 1'b1;
                cnt_next   = '0;
                state_next = C_DIV;
            end
            C_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = C_OUT;
            end
            C_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/rtnp_dpath.sv
// Timing datapath: product, two restoring dividers, output register
`default_nettype none

module rtnp_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rtnp_pkg::note_t               note,
    input  wire rtnp_pkg::cmd_t                cmd,
    output rtnp_pkg::stat_t                    stat,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [rtnp_pkg::TDATA_W-1:0]       out_data,
    output logic [rtnp_pkg::TUSER_W-1:0]       out_user,
    output logic                               out_last
);

    localparam int VW = rtnp_pkg::VAL_W;
    localparam int FW = rtnp_pkg::FREQ_W;
    localparam int DW = rtnp_pkg::DUR_W;
    localparam int GW = rtnp_pkg::GAP_W;
    localparam int PW = rtnp_pkg::PROD_W;

    // Captured note operands
    logic [FW-1:0] freq_reg;
    logic [VW-1:0] tempo_reg, nlen_reg;
    logic          dotted_reg, last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            freq_reg   <= note.freq;
            tempo_reg  <= note.tempo;
            nlen_reg   <= note.nlen;
            dotted_reg <= note.dotted;
            last_reg   <= note.last;
        end
    end

    // Product and divider registers
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] rem_d_reg, rem_d_next;
    logic [DW-1:0] q_d_reg, q_d_next;
    logic [VW-1:0] rem_g_reg, rem_g_next;
    logic [DW-1:0] q_g_reg, q_g_next;
    logic [PW:0]   rsh_d;
    logic [VW:0]   rsh_g;
    logic          ge_d, ge_g;

    // One quotient bit per step for each divider
    always_comb
    begin
        rsh_d      = {rem_d_reg, q_d_reg[DW-1]};
        ge_d       = rsh_d >= {1'b0, prod_reg};
        rem_d_next = ge_d ? PW'(rsh_d - {1'b0, prod_reg}) : rsh_d[PW-1:0];
        q_d_next   = {q_d_reg[DW-2:0], ge_d};
        rsh_g      = {rem_g_reg, q_g_reg[DW-1]};
        ge_g       = rsh_g >= {1'b0, tempo_reg};
        rem_g_next = ge_g ? VW'(rsh_g - {1'b0, tempo_reg}) : rsh_g[VW-1:0];
        q_g_next   = {q_g_reg[DW-2:0], ge_g};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            prod_reg  <= PW'(tempo_reg) * PW'(nlen_reg);
            rem_d_reg <= '0;
            q_d_reg   <= dotted_reg ? rtnp_pkg::NUM_DOTTED : rtnp_pkg::NUM_PLAIN;
            rem_g_reg <= '0;
            q_g_reg   <= rtnp_pkg::NUM_GAP;
        end
        else if (cmd.step)
        begin
            rem_d_reg <= rem_d_next;
            q_d_reg   <= q_d_next;
            rem_g_reg <= rem_g_next;
            q_g_reg   <= q_g_next;
        end
    end

    // Saturate on zero divisors
    logic [DW-1:0] dur_c;
    logic [GW-1:0] gap_c;
    logic          bad_c;

    always_comb
    begin
        bad_c = (tempo_reg == '0);
        dur_c = (prod_reg == '0) ? rtnp_pkg::DUR_MAX : q_d_reg;
        gap_c = bad_c ? rtnp_pkg::GAP_MAX : GW'(q_g_reg);
    end

    // Output register
    logic                          out_valid_reg;
    logic [rtnp_pkg::TDATA_W-1:0]  out_data_reg;
    logic [rtnp_pkg::TUSER_W-1:0]  out_user_reg;
    logic                          out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_data_reg <= {gap_c, dur_c, freq_reg};
            out_user_reg <= {bad_c, (freq_reg == '0)};
            out_last_reg <= last_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign out_user      = out_user_reg;
    assign out_last      = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/rtnp_checker.sv
// Port-level checks for the ringtone text note parser, bound to the top level
`default_nettype none
`include "ringtone_text_note_parser_top_defines.svh"

module rtnp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,
    input wire logic        s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // Hold a stalled item
    `RTNP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `RTNP_ASSERT_NEXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Rest flag follows a zero frequency
    `RTNP_ASSERT_NOW(a_rest_flag, clk, rst_n, m_axis_tvalid, m_axis_tuser[0] == (m_axis_tdata[16:0] == 17'd0))

    // Zero tempo saturates both timings
    `RTNP_ASSERT_NOW(a_bad_tempo, clk, rst_n, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata[33:17] == 17'h1FFFF) && (m_axis_tdata[47:34] == 14'h3FFF))

endmodule

bind ringtone_text_note_parser_top rtnp_checker u_rtnp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: bench/tb_ringtone_text_note_parser_top.sv
// Testbench for the ringtone text note parser: streams tune text and checks each note item
`default_nettype none

module tb_ringtone_text_note_parser_top;

    localparam int          HDR_DIGITS  = 3;
    localparam int unsigned ACC_SAT     = 1023;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          TAIL_CYCLES = 40;

    // Parser position, in text order so that ordered compares follow the note grammar
    typedef enum logic [3:0] {
        AT_NAME, AT_LEN_KEY, AT_LEN_VAL, AT_OCT_KEY, AT_OCT_VAL, AT_BPM_KEY, AT_BPM_VAL,
        AT_LENGTH, AT_THREE, AT_LETTER, AT_SHARP, AT_OCTAVE, AT_DOT, AT_SEP, AT_IDLE
    } parse_phase_t;

    typedef struct packed {
        logic [rtnp_pkg::FREQ_W-1:0] freq;
        logic [rtnp_pkg::DUR_W-1:0]  dur;
        logic [rtnp_pkg::GAP_W-1:0]  gap;
        logic                        is_rest;
        logic                        is_last;
        logic                        bad_tempo;
    } tone_item_t;

    // Octave-4 pitch per tone index, 1/128 Hz
    localparam int unsigned OCT4_PITCH [16] = '{
        0, 66976, 70959, 75178, 79649, 84385, 89402, 94719,
        100351, 106318, 56320, 59669, 63217, 0, 0, 0
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted parser state
    parse_phase_t                parse_at    = AT_IDLE;
    logic [rtnp_pkg::VAL_W-1:0]  acc_value   = '0;
    int unsigned                 acc_digits  = 0;
    logic [rtnp_pkg::VAL_W-1:0]  len_default = '0;
    logic [rtnp_pkg::VAL_W-1:0]  oct_default = '0;
    logic [rtnp_pkg::VAL_W-1:0]  bpm         = '0;
    logic [rtnp_pkg::VAL_W-1:0]  cur_len     = '0;
    logic [3:0]                  cur_tone    = rtnp_pkg::TONE_REST;
    logic [rtnp_pkg::FREQ_W-1:0] held_freq   = '0;
    logic                        cur_dotted  = 1'b0;
    logic                        one_seen    = 1'b0;
    logic [3:0]                  cur_oct     = '0;

    tone_item_t  expected_tones [$];
    tone_item_t  head_tone;
    int unsigned mismatches    = 0;
    int unsigned chars_sent    = 0;
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 55;
    int unsigned hold_requests = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_cycles  = 0;

    string note_lengths [6] = '{"1", "2", "4", "8", "16", "32"};
    string note_letters     = "abcdefgp";

    ringtone_text_note_parser_top #(.HEADER_DIGITS(HDR_DIGITS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Open a fresh note with the header defaults
    function automatic void open_note();
        parse_at   = AT_LENGTH;
        cur_len    = len_default;
        cur_dotted = 1'b0;
        cur_oct    = '0;
        one_seen   = 1'b0;
    endfunction

    // Work out pitch, duration and gap of the finished note and queue it
    function automatic void close_note(input logic ends_tune);
        int unsigned oct;
        int unsigned shift;
        int unsigned pitch;
        int unsigned prod;
        int unsigned dur;
        tone_item_t  want;
        oct = (cur_oct != 0) ? cur_oct : oct_default;
        if (oct >= 4 && oct <= 7)
        begin
            shift = 7 - oct;
            pitch = OCT4_PITCH[cur_tone];
            if (shift != 0)
                pitch = (pitch + (1 << (shift - 1))) >> shift;
            held_freq = pitch[rtnp_pkg::FREQ_W-1:0];
        end
        want.freq = held_freq;
        prod = 32'(bpm) * 32'(cur_len);
        if (prod == 0)
            dur = rtnp_pkg::DUR_MAX;
        else
            dur = (cur_dotted ? 90000 : 60000) / prod;
        if (dur > rtnp_pkg::DUR_MAX)
            dur = rtnp_pkg::DUR_MAX;
        want.dur       = dur[rtnp_pkg::DUR_W-1:0];
        want.gap       = (bpm != 0) ? rtnp_pkg::GAP_W'(9000 / bpm) : rtnp_pkg::GAP_MAX;
        want.is_rest   = (want.freq == 0);
        want.is_last   = ends_tune;
        want.bad_tempo = (bpm == 0);
        expected_tones.push_back(want);
        if (ends_tune)
            parse_at = AT_IDLE;
        else
            open_note();
    endfunction

    // Accumulate one header digit, freeze the field on anything else
    function automatic void take_header_digit(input logic [7:0] c);
        int unsigned v;
        if (c >= rtnp_pkg::CH_0 && c <= rtnp_pkg::CH_9 && acc_digits < HDR_DIGITS)
        begin
            v = acc_value * 10 + (c - rtnp_pkg::CH_0);
            acc_value = (v > ACC_SAT) ? rtnp_pkg::VAL_W'(ACC_SAT) : v[rtnp_pkg::VAL_W-1:0];
            acc_digits++;
        end
        else
            acc_digits = HDR_DIGITS;
    endfunction

    // Advance the note grammar by one character
    function automatic void take_note_char(input logic [7:0] c);
        logic [3:0] idx;
        logic       sharpable;
        logic       hit;
        if (parse_at == AT_THREE)
        begin
            if (c == rtnp_pkg::CH_2)
            begin
                cur_len  = 10'd32;
                parse_at = AT_LETTER;
            end
            else
                close_note(1'b1);
            return;
        end
        if (one_seen)
        begin
            one_seen = 1'b0;
            if (c == rtnp_pkg::CH_6)
            begin
                cur_len = 10'd16;
                return;
            end
        end
        if (parse_at == AT_LENGTH)
        begin
            if (c == rtnp_pkg::CH_3)
            begin
                parse_at = AT_THREE;
                return;
            end
            if (c == rtnp_pkg::CH_1 || c == rtnp_pkg::CH_2 || c == rtnp_pkg::CH_4 ||
                c == rtnp_pkg::CH_8)
            begin
                cur_len  = rtnp_pkg::VAL_W'(c - rtnp_pkg::CH_0);
                one_seen = (c == rtnp_pkg::CH_1);
                parse_at = AT_LETTER;
                return;
            end
        end
        if (parse_at <= AT_LETTER)
        begin
            hit       = 1'b1;
            sharpable = 1'b1;
            idx       = rtnp_pkg::TONE_REST;
            case (c)
                rtnp_pkg::CH_LC: idx = rtnp_pkg::TONE_C;
                rtnp_pkg::CH_LD: idx = rtnp_pkg::TONE_D;
                rtnp_pkg::CH_LF: idx = rtnp_pkg::TONE_F;
                rtnp_pkg::CH_LG: idx = rtnp_pkg::TONE_G;
                rtnp_pkg::CH_LA: idx = rtnp_pkg::TONE_A;
                rtnp_pkg::CH_LE:
                begin
                    idx       = rtnp_pkg::TONE_E;
                    sharpable = 1'b0;
                end
                rtnp_pkg::CH_LB:
                begin
                    idx       = rtnp_pkg::TONE_B;
                    sharpable = 1'b0;
                end
                rtnp_pkg::CH_LP: sharpable = 1'b0;
                default: hit = 1'b0;
            endcase
            if (hit)
            begin
                cur_tone = idx;
                parse_at = sharpable ? AT_SHARP : AT_OCTAVE;
                return;
            end
        end
        if (parse_at == AT_SHARP && c == rtnp_pkg::CH_HASH)
        begin
            cur_tone = cur_tone + 4'd1;
            parse_at = AT_OCTAVE;
            return;
        end
        if (parse_at <= AT_OCTAVE && c >= rtnp_pkg::CH_4 && c <= rtnp_pkg::CH_7)
        begin
            cur_oct  = 4'(c - rtnp_pkg::CH_0);
            parse_at = AT_DOT;
            return;
        end
        if (parse_at <= AT_DOT && c == rtnp_pkg::CH_DOT)
        begin
            cur_dotted = 1'b1;
            parse_at   = AT_SEP;
            return;
        end
        close_note(c != rtnp_pkg::CH_COMMA);
    endfunction

    // Predict the effect of one accepted character
    function automatic void predict_char(input logic [7:0] c, input logic restart);
        if (restart)
        begin
            parse_at   = AT_NAME;
            acc_value  = '0;
            acc_digits = 0;
            cur_tone   = rtnp_pkg::TONE_REST;
            held_freq  = '0;
            return;
        end
        case (parse_at)
            AT_NAME:
                if (c == rtnp_pkg::CH_COLON)
                begin
                    parse_at   = AT_LEN_KEY;
                    acc_digits = 0;
                end
            AT_LEN_KEY, AT_OCT_KEY, AT_BPM_KEY:
            begin
                acc_digits++;
                if (acc_digits >= 2)
                begin
                    parse_at   = parse_phase_t'(parse_at + 1);
                    acc_digits = 0;
                    acc_value  = '0;
                end
            end
            AT_LEN_VAL:
                if (c == rtnp_pkg::CH_COMMA)
                begin
                    len_default = acc_value;
                    parse_at    = AT_OCT_KEY;
                    acc_digits  = 0;
                end
                else
                    take_header_digit(c);
            AT_OCT_VAL:
                if (c == rtnp_pkg::CH_COMMA)
                begin
                    oct_default = acc_value;
                    parse_at    = AT_BPM_KEY;
                    acc_digits  = 0;
                end
                else
                    take_header_digit(c);
            AT_BPM_VAL:
                if (c == rtnp_pkg::CH_COLON)
                begin
                    bpm = acc_value;
                    open_note();
                end
                else
                    take_header_digit(c);
            AT_IDLE: ;
            default: take_note_char(c);
        endcase
    endfunction

    // Offer one character, idling at random first, and predict once it is taken
    task automatic send_char(input logic [7:0] c, input logic restart);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_char(c, restart);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic restart_first);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], restart_first && i == 0);
    endtask

    // Drop valid, wait for every predicted note, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_tones.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Header value text, sometimes empty, over-long or cut by a stray letter
    function automatic string header_digits(input int unsigned v);
        string       d;
        int unsigned pick;
        pick = $urandom_range(99);
        d    = $sformatf("%0d", v);
        if (pick < 5)
            d = "";
        else if (pick < 10)
            d = {d, $sformatf("%0d", $urandom_range(9))};
        else if (pick < 14)
            d = {d, "x", $sformatf("%0d", $urandom_range(9))};
        return d;
    endfunction

    // Two arbitrary key characters, the value digits and the terminator
    task automatic send_field(input string digits, input logic [7:0] term);
        send_char(8'($urandom_range(255)), 1'b0);
        send_char(8'($urandom_range(255)), 1'b0);
        send_text(digits, 1'b0);
        send_char(term, 1'b0);
    endtask

    // Mostly well-formed tunes with random content, some raw noise
    task automatic send_random_tune();
        int unsigned notes;
        int unsigned v;
        logic [7:0]  c;
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(4, 16))
                send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
            return;
        end
        send_char(8'($urandom_range(255)), 1'b1);
        repeat ($urandom_range(3))
        begin
            c = 8'($urandom_range(255));
            send_char((c == rtnp_pkg::CH_COLON) ? rtnp_pkg::CH_LA : c, 1'b0);
        end
        send_char(rtnp_pkg::CH_COLON, 1'b0);
        case ($urandom_range(7))
            0: v = 0;
            1: v = $urandom_range(999);
            default: v = 1 << $urandom_range(5);
        endcase
        send_field(header_digits(v), rtnp_pkg::CH_COMMA);
        v = ($urandom_range(9) == 0) ? $urandom_range(9) : $urandom_range(4, 7);
        send_field(header_digits(v), rtnp_pkg::CH_COMMA);
        case ($urandom_range(9))
            0: v = 0;
            1: v = 1;
            2: v = $urandom_range(1, 999);
            default: v = $urandom_range(25, 400);
        endcase
        send_field(header_digits(v), rtnp_pkg::CH_COLON);
        notes = $urandom_range(1, 10);
        for (int unsigned i = 1; i <= notes; i++)
        begin
            // lone three ends the tune and swallows the next character
            if ($urandom_range(99) < 3)
            begin
                send_char(rtnp_pkg::CH_3, 1'b0);
                send_char(8'($urandom_range(255)), 1'b0);
                return;
            end
            if ($urandom_range(1))
                send_text(note_lengths[$urandom_range(5)], 1'b0);
            if ($urandom_range(99) < 85)
            begin
                c = note_letters[$urandom_range(7)];
                send_char(c, 1'b0);
                if (c != rtnp_pkg::CH_LE && c != rtnp_pkg::CH_LB && c != rtnp_pkg::CH_LP &&
                    $urandom_range(2) == 0)
                    send_char(rtnp_pkg::CH_HASH, 1'b0);
            end
            if ($urandom_range(1))
                send_char(8'(rtnp_pkg::CH_4 + $urandom_range(3)), 1'b0);
            else if ($urandom_range(19) == 0)
                send_char(8'(rtnp_pkg::CH_0 + $urandom_range(9)), 1'b0);
            if ($urandom_range(3) == 0)
                send_char(rtnp_pkg::CH_DOT, 1'b0);
            if (i < notes || $urandom_range(3) == 0)
                send_char(rtnp_pkg::CH_COMMA, 1'b0);
            else
            begin
                c = 8'($urandom_range(255));
                send_char((c == rtnp_pkg::CH_COMMA) ? rtnp_pkg::CH_LP + 8'd1 : c, 1'b0);
            end
        end
    endtask

    // Every letter, sharps, rests, lengths, dots, header corner values and broken endings
    task automatic test_directed();
        send_text("t:d=4,o=5,b=120:c,c#,d#6,e7.,f#4,g#,a#,b,p,8a,16b,32c.,2e,1,1g,3x", 1'b1);
        send_text("n:d=,o=3,b=0:a,4b5,c;zz", 1'b1);
        send_text("q:d=8x9,o=6,b=2500:p.,a#7,16g,r", 1'b1);
        send_text(":m:d=1,o=7,b=1:c.,d;", 1'b1);
        send_text("s:d=0,o=4,b=999:e,32f,16d#.;", 1'b1);
        drain();
    endtask

    task automatic test_random_tunes(input int unsigned count, input int unsigned send_pct,
                                     input int unsigned recv_pct);
        int unsigned stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at       = chars_sent + count;
        while (chars_sent < stop_at)
            send_random_tune();
        drain();
    endtask

    // Hold the output off while a dense tune keeps coming, so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        send_text("h:d=8,o=6,b=180:c,d,e,f,g,a,b,c7,d7,e7,f7,g7,a7,b7,p,c#,d#,f#,g#,a#;", 1'b1);
        drain();
    endtask

    // Drive the output ready, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted note item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tones.size() == 0)
            begin
                $error("note item with nothing predicted: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                head_tone = expected_tones.pop_front();
                check_field("freq_sixteenths", head_tone.freq, m_axis_tdata[16:0]);
                check_field("duration_ms", head_tone.dur, m_axis_tdata[33:17]);
                check_field("gap_ms", head_tone.gap, m_axis_tdata[47:34]);
                check_field("is_rest", head_tone.is_rest, m_axis_tuser[0]);
                check_field("bad_tempo", head_tone.bad_tempo, m_axis_tuser[1]);
                check_field("is_last", head_tone.is_last, m_axis_tlast);
            end
        end
    end

    // Give up when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_tunes(150, 18, 55);
        test_random_tunes(150, 55, 18);
        test_random_tunes(150, 0, 0);
        test_backpressure();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
